// ===== rtl/hsvc_pkg.sv =====
`timescale 1ns / 1ps
// shared constants for the hsv to rgba8 converter
// used by hsvc_to_byte, hsv_to_rgba8_converter and the bench, depends on nothing
package hsvc_pkg;

    localparam int HUE_BITS_DEF       = 16;
    localparam int UNIT_FRAC_BITS_DEF = 15;

    localparam int IN_W     = 16;
    localparam int BYTE_W   = 8;
    localparam int SECTOR_W = 3;

    // color wheel sectors, each one sixth of a turn
    localparam logic [SECTOR_W-1:0] SECTOR_RED_YELLOW    = 3'd0;
    localparam logic [SECTOR_W-1:0] SECTOR_YELLOW_GREEN  = 3'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_GREEN_CYAN    = 3'd2;
    localparam logic [SECTOR_W-1:0] SECTOR_CYAN_BLUE     = 3'd3;
    localparam logic [SECTOR_W-1:0] SECTOR_BLUE_MAGENTA  = 3'd4;

endpackage

// ===== rtl/hsv_to_rgba8_converter.sv =====
`timescale 1ns / 1ps
// hsv plus alpha to rgba8 conversion, five stage pipeline
// depends on hsvc_pkg and hsvc_to_byte
//
// Usage:
//   input channel  : i_in_valid / o_in_ready, payload i_hue, i_saturation,
//                    i_brightness, i_opacity
//   output channel : o_out_valid / i_out_ready, payload o_red, o_green,
//                    o_blue, o_alpha_out
//   Every input transfer gives exactly one output transfer, in order.
//   A pixel passes the stage 1 to stage 5 registers before o_out_valid.
//   Throughput is one pixel per clock while not stalled; the five pipeline registers each
//   hold one pixel, and the 16x16 channel multipliers sit in stage 4.
//   Each stage moves on when the stage after it is empty or moving, so
//   bubbles close up while the receiver stalls; o_in_ready drops only
//   when all five stages are full and i_out_ready is low.
//   Reset (i_rst_n low at a clock edge) empties all stages; nothing is
//   lost or repeated across a stall.
//   Saturation, brightness and opacity above 1.0 are clamped to 1.0.
//   Zero saturation gives grey with truncated scaling.
module hsv_to_rgba8_converter
    import hsvc_pkg::*;
#(
    parameter int HUE_BITS       = HUE_BITS_DEF,
    parameter int UNIT_FRAC_BITS = UNIT_FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [IN_W-1:0]   i_hue,
    input  logic [IN_W-1:0]   i_saturation,
    input  logic [IN_W-1:0]   i_brightness,
    input  logic [IN_W-1:0]   i_opacity,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_red,
    output logic [BYTE_W-1:0] o_green,
    output logic [BYTE_W-1:0] o_blue,
    output logic [BYTE_W-1:0] o_alpha_out
);

    localparam int HW = HUE_BITS;
    localparam int UF = UNIT_FRAC_BITS;
    localparam int UW = UF + 1;
    localparam int NW = 2 * UW;
    localparam int CW = (IN_W > UW) ? IN_W : UW;
    localparam int AW = UW + 8;
    localparam logic [CW-1:0] ONE_C   = CW'(1) << UF;
    localparam logic [UW-1:0] ONE     = UW'(1) << UF;
    localparam logic [AW-1:0] A_HALF  = AW'(1) << (UF - 1);
    localparam logic [UW+HW-1:0] H_HALF = (UW + HW)'(1) << (HW - 1);

    // stage handshake
    logic [5:1] r_vld;
    logic [5:1] w_adv;

    always_comb begin
        w_adv[5] = !r_vld[5] || i_out_ready;
        for (int k = 4; k >= 1; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[1]) r_vld[1] <= i_in_valid;
            for (int k = 2; k <= 5; k++) begin
                if (w_adv[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_in_ready  = w_adv[1];
    assign o_out_valid = r_vld[5];

    // stage 1: clamp units, hue times six
    logic [HW-1:0]       n_hue;
    logic [HW+2:0]       n_hue6;
    logic [UW-1:0]       n_sat, n_val, n_alp;
    logic [CW-1:0]       n_sat_c, n_val_c, n_alp_c;

    assign n_hue   = HW'(i_hue);
    assign n_hue6  = {n_hue, 2'b00} + {1'b0, n_hue, 1'b0};
    assign n_sat_c = CW'(i_saturation);
    assign n_val_c = CW'(i_brightness);
    assign n_alp_c = CW'(i_opacity);
    assign n_sat   = (n_sat_c > ONE_C) ? ONE : n_sat_c[UW-1:0];
    assign n_val   = (n_val_c > ONE_C) ? ONE : n_val_c[UW-1:0];
    assign n_alp   = (n_alp_c > ONE_C) ? ONE : n_alp_c[UW-1:0];

    logic [SECTOR_W-1:0] r_s1_sector;
    logic [HW-1:0]       r_s1_frac;
    logic [UW-1:0]       r_s1_sat, r_s1_val, r_s1_alp;
    logic                r_s1_grey;

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_s1_sector <= n_hue6[HW+2:HW];
            r_s1_frac   <= n_hue6[HW-1:0];
            r_s1_sat    <= n_sat;
            r_s1_val    <= n_val;
            r_s1_alp    <= n_alp;
            r_s1_grey   <= (n_sat == '0);
        end
    end

    // stage 2: s*f rounded, alpha and grey bytes
    logic [UW+HW-1:0] n_sf_prod;
    logic [AW-1:0]    n_val255, n_alp255, n_alp_rnd;

    assign n_sf_prod = (UW + HW)'(r_s1_sat) * (UW + HW)'(r_s1_frac) + H_HALF;
    assign n_val255  = {r_s1_val, 8'd0} - AW'(r_s1_val);
    assign n_alp255  = {r_s1_alp, 8'd0} - AW'(r_s1_alp);
    assign n_alp_rnd = n_alp255 + A_HALF;

    logic [SECTOR_W-1:0] r_s2_sector;
    logic [UW-1:0]       r_s2_sat, r_s2_val, r_s2_sf;
    logic                r_s2_grey;
    logic [BYTE_W-1:0]   r_s2_grey_byte, r_s2_alpha;

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_s2_sector    <= r_s1_sector;
            r_s2_sat       <= r_s1_sat;
            r_s2_val       <= r_s1_val;
            r_s2_sf        <= n_sf_prod[UW+HW-1:HW];
            r_s2_grey      <= r_s1_grey;
            r_s2_grey_byte <= n_val255[UF+7:UF];
            r_s2_alpha     <= r_s1_grey ? n_alp255[UF+7:UF] : n_alp_rnd[UF+7:UF];
        end
    end

    // stage 3: the three channel factors 1-s, 1-sf, 1-(s-sf)
    logic [UW-1:0] n_sinv;
    assign n_sinv = (r_s2_sf > r_s2_sat) ? '0 : (r_s2_sat - r_s2_sf);

    logic [SECTOR_W-1:0] r_s3_sector;
    logic [UW-1:0]       r_s3_val, r_s3_x0, r_s3_x1, r_s3_x2;
    logic                r_s3_grey;
    logic [BYTE_W-1:0]   r_s3_grey_byte, r_s3_alpha;

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_s3_sector    <= r_s2_sector;
            r_s3_val       <= r_s2_val;
            r_s3_x0        <= ONE - r_s2_sat;
            r_s3_x1        <= ONE - r_s2_sf;
            r_s3_x2        <= ONE - n_sinv;
            r_s3_grey      <= r_s2_grey;
            r_s3_grey_byte <= r_s2_grey_byte;
            r_s3_alpha     <= r_s2_alpha;
        end
    end

    // stage 4: channel products
    logic [SECTOR_W-1:0] r_s4_sector;
    logic [NW-1:0]       r_s4_n0, r_s4_n1, r_s4_n2, r_s4_full;
    logic                r_s4_grey;
    logic [BYTE_W-1:0]   r_s4_grey_byte, r_s4_alpha;

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r_s4_sector    <= r_s3_sector;
            r_s4_n0        <= NW'(r_s3_val) * NW'(r_s3_x0);
            r_s4_n1        <= NW'(r_s3_val) * NW'(r_s3_x1);
            r_s4_n2        <= NW'(r_s3_val) * NW'(r_s3_x2);
            r_s4_full      <= NW'(r_s3_val) << UF;
            r_s4_grey      <= r_s3_grey;
            r_s4_grey_byte <= r_s3_grey_byte;
            r_s4_alpha     <= r_s3_alpha;
        end
    end

    // stage 5: sector routing and byte scaling
    logic [NW-1:0]     n_rp, n_gp, n_bp;
    logic [BYTE_W-1:0] n_r8, n_g8, n_b8;

    always_comb begin
        n_rp = r_s4_full;
        n_gp = r_s4_full;
        n_bp = r_s4_full;
        case (r_s4_sector)
            SECTOR_RED_YELLOW: begin
                n_gp = r_s4_n2;
                n_bp = r_s4_n0;
            end
            SECTOR_YELLOW_GREEN: begin
                n_rp = r_s4_n1;
                n_bp = r_s4_n0;
            end
            SECTOR_GREEN_CYAN: begin
                n_rp = r_s4_n0;
                n_bp = r_s4_n2;
            end
            SECTOR_CYAN_BLUE: begin
                n_rp = r_s4_n0;
                n_gp = r_s4_n1;
            end
            SECTOR_BLUE_MAGENTA: begin
                n_rp = r_s4_n2;
                n_gp = r_s4_n0;
            end
            default: begin
                n_gp = r_s4_n0;
                n_bp = r_s4_n1;
            end
        endcase
    end

    hsvc_to_byte #(.UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_red_byte (
        .i_level (n_rp),
        .o_byte  (n_r8)
    );
    hsvc_to_byte #(.UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_green_byte (
        .i_level (n_gp),
        .o_byte  (n_g8)
    );
    hsvc_to_byte #(.UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_blue_byte (
        .i_level (n_bp),
        .o_byte  (n_b8)
    );

    logic [BYTE_W-1:0] r_s5_red, r_s5_green, r_s5_blue, r_s5_alpha;
    logic              r_s5_grey;

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r_s5_red   <= r_s4_grey ? r_s4_grey_byte : n_r8;
            r_s5_green <= r_s4_grey ? r_s4_grey_byte : n_g8;
            r_s5_blue  <= r_s4_grey ? r_s4_grey_byte : n_b8;
            r_s5_alpha <= r_s4_alpha;
            r_s5_grey  <= r_s4_grey;
        end
    end

    assign o_red       = r_s5_red;
    assign o_green     = r_s5_green;
    assign o_blue      = r_s5_blue;
    assign o_alpha_out = r_s5_alpha;

`ifndef SYNTHESIS
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

    a_grey_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_s5_grey |-> o_red == o_green && o_green == o_blue)
        else $error("grey pixel with unequal channels");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) && !i_out_ready |-> !o_in_ready)
        else $error("transfer taken into a full stalled pipeline");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] && !w_adv[3] |=> r_vld[3])
        else $error("stalled stage dropped its pixel");
`endif

endmodule

// ===== rtl/hsvc_to_byte.sv =====
`timescale 1ns / 1ps
// scales a channel level with 2*UNIT_FRAC_BITS fraction bits to a byte,
// rounded half up; depends on hsvc_pkg
module hsvc_to_byte
    import hsvc_pkg::*;
#(
    parameter int UNIT_FRAC_BITS = UNIT_FRAC_BITS_DEF
) (
    input  logic [2*UNIT_FRAC_BITS+1:0] i_level,
    output logic [BYTE_W-1:0]           o_byte
);

    localparam int NW = 2 * UNIT_FRAC_BITS + 2;
    localparam int TW = NW + 8;
    localparam logic [TW-1:0] HALF = TW'(1) << (2 * UNIT_FRAC_BITS - 1);

    logic [TW-1:0] w_scaled;
    logic [9:0]    w_quot;

    // 255*n as (n << 8) - n, then round
    assign w_scaled = {i_level, 8'd0} - TW'(i_level) + HALF;
    assign w_quot   = w_scaled[TW-1:2*UNIT_FRAC_BITS];
    assign o_byte   = (w_quot > 10'd255) ? 8'd255 : w_quot[BYTE_W-1:0];

endmodule

// ===== bench/rgba8_pixel_checker.sv =====
`timescale 1ns / 1ps
// pixel checker for hsv_to_rgba8_converter: watches both channels, predicts
// each rgba8 pixel from the accepted hsva transfer and compares in order
// depends on hsvc_pkg for widths, format defaults and sector codes
module rgba8_pixel_checker
    import hsvc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [IN_W-1:0]   i_hue,
    input  logic [IN_W-1:0]   i_saturation,
    input  logic [IN_W-1:0]   i_brightness,
    input  logic [IN_W-1:0]   i_opacity,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [BYTE_W-1:0] i_red,
    input  logic [BYTE_W-1:0] i_green,
    input  logic [BYTE_W-1:0] i_blue,
    input  logic [BYTE_W-1:0] i_alpha_out,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_compared
);

    localparam int HB = HUE_BITS_DEF;
    localparam int UF = UNIT_FRAC_BITS_DEF;
    localparam logic [63:0] UNIT_ONE = 64'd1 << UF;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
    } rgba8_t;

    typedef struct packed {
        logic [IN_W-1:0] hue;
        logic [IN_W-1:0] sat;
        logic [IN_W-1:0] bright;
        logic [IN_W-1:0] opac;
        rgba8_t          rgba;
    } pixel_entry_t;

    pixel_entry_t expected_pixels[$];
    int           reported = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_compared   = 0;
    end

    function automatic logic [63:0] clamp_unit(input logic [IN_W-1:0] x);
        return ({48'd0, x} > UNIT_ONE) ? UNIT_ONE : {48'd0, x};
    endfunction

    // wide value carries 2*UF fraction bits, round half up
    function automatic logic [BYTE_W-1:0] scale_to_byte(input logic [63:0] wide);
        logic [63:0] b;
        b = (64'd255 * wide + (64'd1 << (2 * UF - 1))) >> (2 * UF);
        return (b > 64'd255) ? 8'hFF : b[BYTE_W-1:0];
    endfunction

    function automatic rgba8_t predict_rgba(input logic [IN_W-1:0] hue,
                                            input logic [IN_W-1:0] sat,
                                            input logic [IN_W-1:0] bright,
                                            input logic [IN_W-1:0] opac);
        logic [63:0] h, s, v, a;
        logic [63:0] h6, sector, frac, sf, s_rest;
        logic [63:0] full, n0, n1, n2, rp, gp, bp, a8, grey;
        rgba8_t      px;
        h = {48'd0, hue} & ((64'd1 << HB) - 64'd1);
        s = clamp_unit(sat);
        v = clamp_unit(bright);
        a = clamp_unit(opac);
        if (s == 64'd0) begin
            // grey path truncates instead of rounding
            grey = (64'd255 * v) >> UF;
            a8   = (64'd255 * a) >> UF;
            px.red   = grey[BYTE_W-1:0];
            px.green = grey[BYTE_W-1:0];
            px.blue  = grey[BYTE_W-1:0];
            px.alpha = a8[BYTE_W-1:0];
        end else begin
            h6     = h * 64'd6;
            sector = h6 >> HB;
            frac   = h6 & ((64'd1 << HB) - 64'd1);
            sf     = (s * frac + (64'd1 << (HB - 1))) >> HB;
            s_rest = (sf > s) ? 64'd0 : s - sf;
            full   = v * UNIT_ONE;
            n0     = v * (UNIT_ONE - s);
            n1     = v * (UNIT_ONE - sf);
            n2     = v * (UNIT_ONE - s_rest);
            rp = full;
            gp = full;
            bp = full;
            case (sector[SECTOR_W-1:0])
                SECTOR_RED_YELLOW: begin
                    gp = n2; bp = n0;
                end
                SECTOR_YELLOW_GREEN: begin
                    rp = n1; bp = n0;
                end
                SECTOR_GREEN_CYAN: begin
                    rp = n0; bp = n2;
                end
                SECTOR_CYAN_BLUE: begin
                    rp = n0; gp = n1;
                end
                SECTOR_BLUE_MAGENTA: begin
                    rp = n2; gp = n0;
                end
                default: begin
                    gp = n0; bp = n1;
                end
            endcase
            a8 = (64'd255 * a + (UNIT_ONE >> 1)) >> UF;
            if (a8 > 64'd255)
                a8 = 64'd255;
            px.red   = scale_to_byte(rp);
            px.green = scale_to_byte(gp);
            px.blue  = scale_to_byte(bp);
            px.alpha = a8[BYTE_W-1:0];
        end
        return px;
    endfunction

    always @(posedge i_clk) begin
        pixel_entry_t entry;
        rgba8_t       got;
        if (!i_rst_n) begin
            expected_pixels.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                entry.hue    = i_hue;
                entry.sat    = i_saturation;
                entry.bright = i_brightness;
                entry.opac   = i_opacity;
                entry.rgba   = predict_rgba(i_hue, i_saturation, i_brightness, i_opacity);
                expected_pixels.push_back(entry);
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_red, i_green, i_blue, i_alpha_out};
                if (expected_pixels.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (reported < REPORT_LIMIT)
                        $display("%0t: output transfer with no pixel pending: %h %h %h %h",
                                 $realtime, i_red, i_green, i_blue, i_alpha_out);
                    reported++;
                end else begin
                    entry = expected_pixels.pop_front();
                    o_compared <= o_compared + 1;
                    if (got.red !== entry.rgba.red || got.green !== entry.rgba.green ||
                        got.blue !== entry.rgba.blue || got.alpha !== entry.rgba.alpha) begin
                        o_fail_count <= o_fail_count + 1;
                        if (reported < REPORT_LIMIT)
                            $display("%0t: hsva %h %h %h %h: expected rgba %h %h %h %h, got %h %h %h %h",
                                     $realtime, entry.hue, entry.sat, entry.bright, entry.opac,
                                     entry.rgba.red, entry.rgba.green, entry.rgba.blue,
                                     entry.rgba.alpha, got.red, got.green, got.blue, got.alpha);
                        reported++;
                    end
                end
            end
        end
        o_pending <= expected_pixels.size();
    end

endmodule

// ===== bench/tb_hsv_to_rgba8_converter.sv =====
`timescale 1ns / 1ps
// top of the hsv_to_rgba8_converter bench: clock, reset, hsva stimulus and verdict
// depends on hsvc_pkg, hsv_to_rgba8_converter and rgba8_pixel_checker
module tb_hsv_to_rgba8_converter;
    import hsvc_pkg::*;

    localparam int STALL_CYCLES = 60;
    localparam int DRAIN_LIMIT  = 2000;
    localparam logic [IN_W-1:0] UNIT = 16'd32768;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              out_ready = 1'b0;
    logic [IN_W-1:0]   hue       = '0;
    logic [IN_W-1:0]   sat       = '0;
    logic [IN_W-1:0]   bright    = '0;
    logic [IN_W-1:0]   opac      = '0;
    logic              in_ready;
    logic              out_valid;
    logic [BYTE_W-1:0] red, green, blue, alpha;

    int fail_count, pending, compared;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_req     = 0;
    int stall_done    = 0;
    int stall_left    = 0;
    int sent_total    = 0;
    int grey_total    = 0;
    int clamped_total = 0;
    int leftover      = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    hsv_to_rgba8_converter i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_hue        (hue),
        .i_saturation (sat),
        .i_brightness (bright),
        .i_opacity    (opac),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_red        (red),
        .o_green      (green),
        .o_blue       (blue),
        .o_alpha_out  (alpha)
    );

    rgba8_pixel_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_hue        (hue),
        .i_saturation (sat),
        .i_brightness (bright),
        .i_opacity    (opac),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_red        (red),
        .i_green      (green),
        .i_blue       (blue),
        .i_alpha_out  (alpha),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_compared   (compared)
    );

    // receiver: random stalls, plus a long hold-off whenever one is requested
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (stall_done != stall_req) begin
            stall_done++;
            stall_left = STALL_CYCLES - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // entered and left at a falling edge
    task automatic send_pixel(input logic [IN_W-1:0] h, input logic [IN_W-1:0] s,
                              input logic [IN_W-1:0] v, input logic [IN_W-1:0] a);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        hue      <= h;
        sat      <= s;
        bright   <= v;
        opac     <= a;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        sent_total++;
        if (s == '0)
            grey_total++;
        if (s > UNIT || v > UNIT || a > UNIT)
            clamped_total++;
    endtask

    // unit fields lean on zero, exactly one, and values above one
    function automatic logic [IN_W-1:0] pick_unit();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        else if (r < 16)
            return UNIT;
        else if (r < 26)
            return IN_W'($urandom_range(65535, 32769));
        else if (r < 32)
            return IN_W'($urandom_range(7));
        else
            return IN_W'($urandom_range(32767));
    endfunction

    // some hues land on or near a sector border
    function automatic logic [IN_W-1:0] pick_hue();
        int border;
        if ($urandom_range(99) < 15) begin
            border = (int'($urandom_range(5)) * 65536 + 3) / 6;
            return IN_W'(border + int'($urandom_range(6)) - 3);
        end
        return IN_W'($urandom_range(65535));
    endfunction

    task automatic send_random(input int count);
        for (int k = 0; k < count; k++)
            send_pixel(pick_hue(), pick_unit(), pick_unit(), pick_unit());
    endtask

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int waited;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 6;
        recv_idle_pct = 62;
        send_pixel(16'd0, UNIT, UNIT, UNIT);
        send_pixel(16'hFFFF, UNIT, UNIT, UNIT);
        // hues on either side of each sector border
        send_pixel(16'd10922, 16'd20000, 16'd30000, 16'd16384);
        send_pixel(16'd10923, 16'd20000, 16'd30000, 16'd16384);
        send_pixel(16'd21845, 16'd20000, 16'd30000, 16'd16384);
        send_pixel(16'd21846, 16'd20000, 16'd30000, 16'd16384);
        send_pixel(16'd32767, 16'd20000, 16'd30000, 16'd16384);
        send_pixel(16'd32768, 16'd20000, 16'd30000, 16'd16384);
        send_pixel(16'd43690, 16'd20000, 16'd30000, 16'd16384);
        send_pixel(16'd43691, 16'd20000, 16'd30000, 16'd16384);
        send_pixel(16'd54613, 16'd20000, 16'd30000, 16'd16384);
        send_pixel(16'd54614, 16'd20000, 16'd30000, 16'd16384);
        // grey with truncation
        send_pixel(16'd5000, 16'd0, UNIT, UNIT);
        send_pixel(16'd5000, 16'd0, 16'd32767, 16'd1);
        send_pixel(16'd0, 16'd0, 16'd0, 16'd0);
        // inputs above one get clamped, followed by other corner cases
        send_pixel(16'd40000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'd40000, 16'd32769, 16'd50000, 16'd32769);
        send_pixel(16'd12345, 16'd1, UNIT, 16'd0);
        send_pixel(16'd30000, UNIT, 16'd0, UNIT);
        send_pixel(16'd60000, 16'd16384, 16'd16384, 16'd32767);
        send_random(440);

        send_idle_pct = 62;
        recv_idle_pct = 6;
        send_random(450);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(200);
        stall_req++;
        send_random(240);
        in_valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        leftover = pending;
        if (leftover != 0)
            $display("%0d pixels never came out", leftover);
        repeat (10) @(posedge clk);

        $display("sent %0d hsva pixels (%0d grey, %0d with clamped fields), %0d compared,",
                 sent_total, grey_total, clamped_total, compared);
        $display("under sender-heavy, receiver-heavy and free-running stalls plus one long hold-off");
        if (fail_count == 0 && leftover == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
